### src/gamma_runlength_bit_decoder_core_defines.svh
// assertion macros used by the decoder core
`ifndef GAMMA_RUNLENGTH_BIT_DECODER_CORE_DEFINES_SVH
`define GAMMA_RUNLENGTH_BIT_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge out of reset
`define GRD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grd assertion failed");
// next-cycle implication
`define GRD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grd assertion failed");
`else
`define GRD_ASSERT_IMP(label, ante, cons)
`define GRD_ASSERT_NXT(label, ante, cons)
`endif
`endif

### src/grd_pkg.sv
`timescale 1ns / 1ps
package grd_pkg;

    // leading zero limit, capped so a value fits in nine bits
    localparam int unsigned MaxZeros = 8;
    localparam int unsigned ZcW      = 4;
    localparam int unsigned RunW     = 9;
    localparam int unsigned SymW     = 8;
    localparam int unsigned CntW     = 4;
    localparam int unsigned FbbW     = 3;
    localparam int unsigned CfgIdxW  = 1;
    localparam logic [ZcW-1:0] ZeroLimit = (MaxZeros < 8) ? ZcW'(MaxZeros) : ZcW'(8);

    // register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_START_BIT       = 1'b0,
        CFG_FIRST_BYTE_BITS = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ERR
    } t_pack_state;

    // request from the codeword parser to the packer
    typedef struct packed {
        logic            run;
        logic            err;
        logic [RunW-1:0] len;
    } t_run_req;

    typedef struct packed {
        logic            busy;
        logic [CntW-1:0] pack_count;
    } t_pack_status;

    // low k bits set, k from 0 to 8
    function automatic logic [SymW-1:0] ones_mask(input logic [CntW-1:0] k);
        logic [SymW:0] m;
        m = ({{SymW{1'b0}}, 1'b1} << k) - {{SymW{1'b0}}, 1'b1};
        return m[SymW-1:0];
    endfunction

endpackage

### src/grd_ifs.sv
`timescale 1ns / 1ps
// code bit channel
interface grd_code_if;
    logic valid;
    logic ready;
    logic code_bit;
    logic frame_start;
    modport source(output valid, code_bit, frame_start, input ready);
    modport sink(input valid, code_bit, frame_start, output ready);
endinterface

// decoded symbol channel
interface grd_sym_if import grd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [SymW-1:0] out_symbol;
    logic [CntW-1:0] symbol_bits;
    logic            code_error;
    logic            last_of_run;
    modport source(output valid, out_symbol, symbol_bits, code_error, last_of_run,
                   input ready);
    modport sink(input valid, out_symbol, symbol_bits, code_error, last_of_run,
                 output ready);
endinterface

// register write channel
interface grd_cfg_if import grd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [FbbW-1:0]    data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

### src/grd_gamma.sv
`timescale 1ns / 1ps
module grd_gamma import grd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  logic     i_code_bit,
    input  logic     i_frame_start,
    output t_run_req o_req
);

    logic            r_reading, n_reading;
    logic [ZcW-1:0]  r_zero_count, n_zero_count;
    logic [RunW-1:0] r_value_acc, n_value_acc;
    logic [ZcW-1:0]  r_bits_left, n_bits_left;
    logic            r_err_hold, n_err_hold;

    logic            c_reading;
    logic [ZcW-1:0]  c_zero_count;
    logic [RunW-1:0] c_value_acc;
    logic [ZcW-1:0]  c_bits_left;
    logic            c_err_hold;
    logic [RunW-1:0] acc_shift;
    logic [ZcW-1:0]  bl_dec;

    // codeword parse for the offered bit, frame start clears first
    always_comb begin
        c_reading    = i_frame_start ? 1'b0 : r_reading;
        c_zero_count = i_frame_start ? '0 : r_zero_count;
        c_value_acc  = i_frame_start ? '0 : r_value_acc;
        c_bits_left  = i_frame_start ? '0 : r_bits_left;
        c_err_hold   = i_frame_start ? 1'b0 : r_err_hold;
        acc_shift    = {c_value_acc[RunW-2:0], i_code_bit};
        bl_dec       = c_bits_left - ZcW'(1);

        n_reading    = c_reading;
        n_zero_count = c_zero_count;
        n_value_acc  = c_value_acc;
        n_bits_left  = c_bits_left;
        n_err_hold   = c_err_hold;
        o_req        = '0;

        if (!c_err_hold) begin
            if (!c_reading) begin
                if (!i_code_bit) begin
                    if (c_zero_count >= ZeroLimit) begin
                        o_req.err  = 1'b1;
                        n_err_hold = 1'b1;
                    end else begin
                        n_zero_count = c_zero_count + ZcW'(1);
                    end
                end else begin
                    n_zero_count = '0;
                    n_bits_left  = c_zero_count;
                    if (c_zero_count == '0) begin
                        // single-bit codeword: run of one
                        o_req.run   = 1'b1;
                        o_req.len   = RunW'(1);
                        n_value_acc = '0;
                    end else begin
                        n_value_acc = RunW'(1);
                        n_reading   = 1'b1;
                    end
                end
            end else begin
                n_bits_left = bl_dec;
                if (bl_dec == '0) begin
                    o_req.run   = 1'b1;
                    o_req.len   = acc_shift;
                    n_value_acc = '0;
                    n_reading   = 1'b0;
                end else begin
                    n_value_acc = acc_shift;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading    <= 1'b0;
            r_zero_count <= '0;
            r_value_acc  <= '0;
            r_bits_left  <= '0;
            r_err_hold   <= 1'b0;
        end else if (i_accept) begin
            r_reading    <= n_reading;
            r_zero_count <= n_zero_count;
            r_value_acc  <= n_value_acc;
            r_bits_left  <= n_bits_left;
            r_err_hold   <= n_err_hold;
        end
    end

endmodule

### src/grd_pack.sv
`timescale 1ns / 1ps
module grd_pack import grd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_frame_start,
    input  t_run_req        i_req,
    input  logic            i_start_bit,
    input  logic [FbbW-1:0] i_first_byte_bits,
    output logic            o_in_ready,
    output t_pack_status    o_status,
    grd_sym_if.source       o_sym
);

    t_pack_state     r_state, n_state;
    logic [RunW-1:0] r_remain, n_remain;
    logic [SymW-1:0] r_pack, n_pack;
    logic [CntW-1:0] r_count, n_count;
    logic            r_first, n_first;
    logic            r_pol, n_pol;
    logic            r_out_valid, n_out_valid;
    logic [SymW-1:0] r_out_symbol, n_out_symbol;
    logic [CntW-1:0] r_out_bits, n_out_bits;
    logic            r_out_err, n_out_err;
    logic            r_out_last, n_out_last;

    logic                 out_free;
    logic                 load;
    logic [CntW-1:0]      target;
    logic [CntW-1:0]      need;
    logic [CntW-1:0]      k;
    logic [2*SymW-1:0]    shifted;
    logic [SymW-1:0]      merged;
    logic [CntW-1:0]      cnt_sum;
    logic                 emit;
    logic [RunW-1:0]      rem_after;

    // merge unit: up to one symbol's worth of same-polarity bits per cycle while the output register is free
    always_comb begin
        out_free  = !r_out_valid || o_sym.ready;
        target    = (r_first && (i_first_byte_bits != '0)) ?
                    CntW'(i_first_byte_bits) : CntW'(SymW);
        need      = (r_count >= target) ? CntW'(1) : (target - r_count);
        k         = (r_remain < RunW'(need)) ? r_remain[CntW-1:0] : need;
        shifted   = {{SymW{1'b0}}, r_pack} << k;
        merged    = shifted[SymW-1:0] | (r_pol ? ones_mask(k) : '0);
        cnt_sum   = r_count + k;
        emit      = (cnt_sum >= target);
        rem_after = r_remain - RunW'(k);
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_remain     = r_remain;
        n_pack       = r_pack;
        n_count      = r_count;
        n_first      = r_first;
        n_pol        = r_pol;
        n_out_symbol = r_out_symbol;
        n_out_bits   = r_out_bits;
        n_out_err    = r_out_err;
        n_out_last   = r_out_last;
        load         = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    if (i_frame_start) begin
                        // partial symbol is dropped
                        n_pack  = '0;
                        n_count = '0;
                        n_first = 1'b1;
                        n_pol   = i_start_bit;
                    end
                    if (i_req.err) begin
                        n_state = ST_ERR;
                    end else if (i_req.run) begin
                        n_remain = i_req.len;
                        n_state  = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    n_remain = rem_after;
                    if (emit) begin
                        n_pack       = '0;
                        n_count      = '0;
                        n_first      = 1'b0;
                        load         = 1'b1;
                        n_out_symbol = merged;
                        n_out_bits   = cnt_sum;
                        n_out_err    = 1'b0;
                        // no further symbol can complete with fewer than 8 bits left
                        n_out_last   = (rem_after < RunW'(SymW));
                    end else begin
                        n_pack  = merged;
                        n_count = cnt_sum;
                    end
                    if (rem_after == '0) begin
                        n_pol   = ~r_pol;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    load         = 1'b1;
                    n_out_symbol = '0;
                    n_out_bits   = '0;
                    n_out_err    = 1'b1;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        n_out_valid = load ? 1'b1 : (o_sym.ready ? 1'b0 : r_out_valid);
    end

    // control and packing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_remain    <= '0;
            r_pack      <= '0;
            r_count     <= '0;
            r_first     <= 1'b1;
            r_pol       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remain    <= n_remain;
            r_pack      <= n_pack;
            r_count     <= n_count;
            r_first     <= n_first;
            r_pol       <= n_pol;
            r_out_valid <= n_out_valid;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        r_out_symbol <= n_out_symbol;
        r_out_bits   <= n_out_bits;
        r_out_err    <= n_out_err;
        r_out_last   <= n_out_last;
    end

    assign o_in_ready          = (r_state == ST_IDLE);
    assign o_status.busy       = (r_state != ST_IDLE);
    assign o_status.pack_count = r_count;

    assign o_sym.valid       = r_out_valid;
    assign o_sym.out_symbol  = r_out_symbol;
    assign o_sym.symbol_bits = r_out_bits;
    assign o_sym.code_error  = r_out_err;
    assign o_sym.last_of_run = r_out_last;

endmodule

### src/gamma_runlength_bit_decoder_core.sv
`timescale 1ns / 1ps
// Elias gamma run-length decoder: takes one code bit per word on i_code, and for each
// finished codeword expands the run of alternating polarity (first run from start_bit)
// into MSB-first packed symbols on o_symbol; the first symbol of a frame carries
// first_byte_bits bits (0 = 8), later ones 8. A codeword's run is expanded by the
// single shift-and-mask packer, which moves up to one symbol's worth of bits per merge
// step and stalls while o_symbol is held off; no new code bit is taken until the run is
// expanded. Too many leading zeros yields one error word (code_error = 1, symbol_bits = 0)
// and further bits are dropped until a frame_start. Registers (index 0 start_bit, index 1
// first_byte_bits) are written on i_cfg, always ready; the user must write them only while
// idle, as the block itself does not enforce it.
`include "gamma_runlength_bit_decoder_core_defines.svh"
module gamma_runlength_bit_decoder_core import grd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    grd_code_if.sink  i_code,
    grd_cfg_if.sink   i_cfg,
    grd_sym_if.source o_symbol
);

    logic            r_start_bit;
    logic [FbbW-1:0] r_first_byte_bits;
    logic            accept;
    logic            in_ready;
    t_run_req        req;
    t_pack_status    status;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bit       <= 1'b0;
            r_first_byte_bits <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_START_BIT:       r_start_bit       <= i_cfg.data[0];
                CFG_FIRST_BYTE_BITS: r_first_byte_bits <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_code.ready = in_ready;
    assign accept       = i_code.valid && in_ready;

    // codeword parser
    grd_gamma u_gamma (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_code_bit    (i_code.code_bit),
        .i_frame_start (i_code.frame_start),
        .o_req         (req)
    );

    // run expansion and symbol packing
    grd_pack u_pack (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_frame_start     (i_code.frame_start),
        .i_req             (req),
        .i_start_bit       (r_start_bit),
        .i_first_byte_bits (r_first_byte_bits),
        .o_in_ready        (in_ready),
        .o_status          (status),
        .o_sym             (o_symbol)
    );

    // error word is a lone, empty, final word
    `GRD_ASSERT_IMP(a_err_word, o_symbol.valid && o_symbol.code_error, o_symbol.last_of_run && o_symbol.symbol_bits == '0 && o_symbol.out_symbol == '0)
    // data words carry between one and eight bits
    `GRD_ASSERT_IMP(a_sym_bits, o_symbol.valid && !o_symbol.code_error, o_symbol.symbol_bits != '0 && o_symbol.symbol_bits <= CntW'(SymW))
    // frame start drops the partial symbol
    `GRD_ASSERT_NXT(a_frame_clear, accept && i_code.frame_start, status.pack_count == '0)
    // between codewords the packer never holds a full symbol
    `GRD_ASSERT_IMP(a_idle_partial, !status.busy, status.pack_count < CntW'(SymW))

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb import grd_pkg::*; ();

    localparam int Limit        = 300000;
    localparam int SettleCycles = 80;
    localparam int LongHold     = 400;
    localparam int TailCycles   = 100;
    localparam int PhaseItems   = 12;

    // one decoded symbol word as seen on the output channel
    typedef struct {
        logic [SymW-1:0] symbol;
        logic [CntW-1:0] nbits;
        logic            err;
        logic            last_flag;
    } t_sym_word;

    // gamma decode and run expansion, plus the queue of symbol words still owed
    class t_symbol_scoreboard;
        bit               cfg_start_bit;
        bit [FbbW-1:0]    cfg_first_bits;
        bit               reading_value;
        bit [ZcW-1:0]     zero_count;
        bit [RunW-1:0]    value_acc;
        bit [3:0]         bits_left;
        bit               run_polarity;
        bit [SymW-1:0]    pack_reg;
        bit [CntW-1:0]    pack_count;
        bit               first_pending;
        bit               error_hold;
        t_sym_word        expected[$];
        int               errors;

        function new();
            cfg_start_bit  = 1'b0;
            cfg_first_bits = '0;
            errors         = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            reading_value = 1'b0;
            zero_count    = '0;
            value_acc     = '0;
            bits_left     = '0;
            run_polarity  = cfg_start_bit;
            pack_reg      = '0;
            pack_count    = '0;
            first_pending = 1'b1;
            error_hold    = 1'b0;
        endfunction

        function void note_code(logic code_bit, logic frame_start);
            t_sym_word fresh[$];
            t_sym_word w;
            bit        run_done;
            int        target;
            int        i;
            run_done = 1'b0;
            if (frame_start)
                clear_frame();
            if (error_hold)
                return;
            // codeword parse: leading zeros, then the value bits
            if (!reading_value) begin
                if (!code_bit) begin
                    if (zero_count >= ZeroLimit) begin
                        w = '{8'h00, 4'd0, 1'b1, 1'b0};
                        fresh = {fresh, w};
                        error_hold = 1'b1;
                    end else begin
                        zero_count++;
                    end
                end else begin
                    value_acc  = 9'd1;
                    bits_left  = zero_count;
                    zero_count = '0;
                    if (bits_left == 0)
                        run_done = 1'b1;
                    else
                        reading_value = 1'b1;
                end
            end else begin
                value_acc = {value_acc[RunW-2:0], code_bit};
                bits_left--;
                if (bits_left == 0) begin
                    reading_value = 1'b0;
                    run_done      = 1'b1;
                end
            end
            // expand the run and pack msb first
            if (run_done) begin
                for (i = 0; i < value_acc; i++) begin
                    pack_reg = {pack_reg[SymW-2:0], run_polarity};
                    pack_count++;
                    target = (first_pending && cfg_first_bits != 0) ? cfg_first_bits : 8;
                    if (pack_count >= target) begin
                        w = '{pack_reg, pack_count, 1'b0, 1'b0};
                        fresh = {fresh, w};
                        pack_reg      = '0;
                        pack_count    = '0;
                        first_pending = 1'b0;
                    end
                end
                run_polarity = ~run_polarity;
                value_acc    = '0;
            end
            foreach (fresh[k]) begin
                w = fresh[k];
                w.last_flag = (k == fresh.size() - 1);
                expected = {expected, w};
            end
        endfunction

        function void check_symbol(t_sym_word got);
            t_sym_word want;
            if (expected.size() == 0) begin
                $display("%0t: unexpected symbol word sym %h bits %0d err %0d last %0d",
                         $time, got.symbol, got.nbits, got.err, got.last_flag);
                errors++;
                return;
            end
            want = expected.pop_front();
            if (got.symbol !== want.symbol) begin
                $display("%0t: out_symbol exp %h got %h", $time, want.symbol, got.symbol);
                errors++;
            end
            if (got.nbits !== want.nbits) begin
                $display("%0t: symbol_bits exp %0d got %0d", $time, want.nbits, got.nbits);
                errors++;
            end
            if (got.err !== want.err) begin
                $display("%0t: code_error exp %0d got %0d", $time, want.err, got.err);
                errors++;
            end
            if (got.last_flag !== want.last_flag) begin
                $display("%0t: last_of_run exp %0d got %0d", $time, want.last_flag,
                         got.last_flag);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    grd_code_if code_if ();
    grd_cfg_if  cfg_if ();
    grd_sym_if  sym_if ();

    t_symbol_scoreboard sb;
    bit idle_on;
    bit long_hold_req;
    int cycles;

    gamma_runlength_bit_decoder_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_code   (code_if),
        .i_cfg    (cfg_if),
        .o_symbol (sym_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > Limit) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // symbol receiver: random short stalls, one long hold on request
    initial begin : symbol_sink
        int gap;
        sym_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                sym_if.ready <= 1'b0;
                repeat (LongHold) @(negedge i_clk);
                long_hold_req = 1'b0;
                sym_if.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 7);
                sym_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                sym_if.ready <= 1'b1;
            end else begin
                sym_if.ready <= 1'b1;
            end
        end
    end

    // symbol monitor
    always @(posedge i_clk) begin : symbol_monitor
        t_sym_word got;
        if (i_rst_n && sym_if.valid && sym_if.ready) begin
            got = '{sym_if.out_symbol, sym_if.symbol_bits, sym_if.code_error,
                    sym_if.last_of_run};
            sb.check_symbol(got);
        end
    end

    // offer one code bit word and wait for it to be taken
    task automatic send_code(input logic b, input logic fs);
        code_if.valid       <= 1'b1;
        code_if.code_bit    <= b;
        code_if.frame_start <= fs;
        do @(posedge i_clk); while (!code_if.ready);
        sb.note_code(b, fs);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            code_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
    endtask

    // one well-formed codeword: nz zeros, a one, then nz random value bits
    task automatic send_run(input logic fs_first, input int nz);
        int i;
        for (i = 0; i < nz; i++)
            send_code(1'b0, (i == 0) ? fs_first : 1'b0);
        send_code(1'b1, (nz == 0) ? fs_first : 1'b0);
        for (i = 0; i < nz; i++)
            send_code(1'($urandom_range(0, 1)), 1'b0);
    endtask

    // stop sending, wait for every owed word, then let the packer settle
    task automatic quiesce();
        code_if.valid <= 1'b0;
        while (sb.expected.size() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    // write both registers back to back
    task automatic set_config(input bit sbit, input bit [FbbW-1:0] fbb);
        int k;
        for (k = 0; k < 2; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= (k == 0) ? CFG_START_BIT : CFG_FIRST_BYTE_BITS;
            cfg_if.data  <= (k == 0) ? {{(FbbW-1){1'b0}}, sbit} : fbb;
            do @(posedge i_clk); while (!cfg_if.ready);
            if (k == 0)
                sb.cfg_start_bit = sbit;
            else
                sb.cfg_first_bits = fbb;
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // stimulus
    initial begin : stimulus
        int ph;
        int sent;
        int pick;
        int nz;
        int i;
        bit need_fs;
        bit sbv;
        bit [FbbW-1:0] fbbv;
        bit phase_sb [4]  = '{1'b1, 1'b0, 1'b1, 1'b0};
        int phase_fbb [4] = '{7, 1, 0, 3};

        sb = new();
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        cycles        = 0;
        i_rst_n             = 1'b0;
        code_if.valid       = 1'b0;
        code_if.code_bit    = 1'b0;
        code_if.frame_start = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.index        = CFG_START_BIT;
        cfg_if.data         = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: shortest runs, then the longest codeword
        send_run(1'b1, 0);
        send_run(1'b0, 0);
        send_code(1'b0, 1'b0);
        for (i = 0; i < 7; i++)
            send_code(1'b0, 1'b0);
        send_code(1'b1, 1'b0);
        for (i = 0; i < 8; i++)
            send_code(1'b1, 1'b0);

        // directed: shrink the first symbol below the bits already packed
        quiesce();
        send_code(1'b0, 1'b1);
        send_code(1'b0, 1'b0);
        send_code(1'b1, 1'b0);
        send_code(1'b0, 1'b0);
        send_code(1'b1, 1'b0);
        quiesce();
        set_config(1'b0, 3'd2);
        send_code(1'b1, 1'b0);

        // directed: too many leading zeros, then a bit that is dropped
        for (i = 0; i < 9; i++)
            send_code(1'b0, (i == 0));
        send_code(1'b1, 1'b0);

        // random phases, each with its own register setting
        for (ph = 0; ph < 5; ph++) begin
            quiesce();
            sbv  = (ph < 4) ? phase_sb[ph] : 1'($urandom_range(0, 1));
            fbbv = (ph < 4) ? FbbW'(phase_fbb[ph]) : FbbW'($urandom_range(0, 7));
            set_config(sbv, fbbv);
            idle_on = (ph != 4);
            need_fs = ($urandom_range(0, 3) != 0);
            sent    = 0;
            // back up the output with a long run while the receiver holds off
            if (ph == 1) begin
                long_hold_req = 1'b1;
                send_run(1'b1, 8);
                need_fs = 1'b0;
            end
            while (sent < PhaseItems) begin
                pick = $urandom_range(0, 15);
                if (pick < 11) begin
                    pick = $urandom_range(0, 15);
                    nz   = (pick < 12) ? pick % 4 : $urandom_range(4, 8);
                    send_run(need_fs, nz);
                    sent += 2 * nz + 1;
                    need_fs = 1'b0;
                end else if (pick < 13) begin
                    // noise bit
                    send_code(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    sent++;
                end else if (pick < 15) begin
                    // codeword cut short, next one starts a new frame
                    nz = $urandom_range(1, 8);
                    for (i = 0; i < nz; i++)
                        send_code(1'b0, need_fs && i == 0);
                    send_code(1'b1, 1'b0);
                    for (i = 0; i < nz - 1; i++)
                        send_code(1'($urandom_range(0, 1)), 1'b0);
                    sent += 2 * nz;
                    need_fs = 1'b1;
                end else begin
                    // zero limit broken, trailing bits dropped
                    for (i = 0; i < 9; i++)
                        send_code(1'b0, (i == 0));
                    send_code(1'($urandom_range(0, 1)), 1'b0);
                    send_code(1'($urandom_range(0, 1)), 1'b0);
                    sent += 11;
                    need_fs = 1'b1;
                end
            end
            // sender pause in the middle of the run
            if (ph == 2)
                quiesce();
        end

        quiesce();
        repeat (TailCycles) @(negedge i_clk);
        if (sb.expected.size() != 0) begin
            $display("%0t: %0d symbol words never arrived, first exp %h/%0d",
                     $time, sb.expected.size(), sb.expected[0].symbol,
                     sb.expected[0].nbits);
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/grd_pkg.sv
src/grd_ifs.sv
src/grd_gamma.sv
src/grd_pack.sv
src/gamma_runlength_bit_decoder_core.sv
tb/sv/tb.sv
